>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the design checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define APL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define APL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/apl_pkg.sv
// ----------------------------------------------------------------------------
// apl_pkg
// shared types and constants for the adc piecewise linear correction block
// ----------------------------------------------------------------------------
package apl_pkg;

    localparam int DEF_NUM_POINTS = 34;
    localparam int DEF_ADC_BITS   = 12;
    localparam int IDX_W          = 6;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WALK,
        S_MUL,
        S_DIV,
        S_FIX,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_wr;
        logic start;
        logic rd_step;
        logic walk_en;
        logic mul_en;
        logic div_step;
        logic fix_en;
        logic set_full;
        logic set_beyond;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic raw_full;
        logic hit;
        logic last;
        logic div_last;
    } t_status;

endpackage

>>> design/adc_piecewise_linear_correction.sv
// ----------------------------------------------------------------------------
// adc_piecewise_linear_correction
// adc code linearization over a table of calibration breakpoints
// ----------------------------------------------------------------------------
//  channel   direction   handshake                  payload
//  in        to block    i_in_valid / o_in_stall    kind, point fields, raw code
//  out       from block  o_out_valid / i_out_stall  corrected code, beyond flag
//
//  a load transfer writes one breakpoint and does not stall the input
//  a sample is worked through by the one-slot-per-cycle walk of the
//  breakpoint memory and the one-bit-per-cycle divider; full-scale samples
//  skip both the walk and the divider
//  synchronous active-low reset marks every breakpoint slot as unused at once
//  a finished result waits in the output register; a new transfer is taken
//  meanwhile, and only a second result stalls behind it
// ----------------------------------------------------------------------------
module adc_piecewise_linear_correction #(
    parameter int NUM_POINTS = apl_pkg::DEF_NUM_POINTS,
    parameter int ADC_BITS   = apl_pkg::DEF_ADC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_kind,
    input  logic [apl_pkg::IDX_W-1:0] i_point_index,
    input  logic [ADC_BITS-1:0]       i_point_measured,
    input  logic [ADC_BITS-1:0]       i_point_ideal,
    input  logic [ADC_BITS-1:0]       i_raw_code,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [ADC_BITS-1:0]       o_corrected_code,
    output logic                      o_beyond_table
);
    import apl_pkg::*;

    t_cmd    cmd;
    t_status status;

    // controller: accepts transfers, sequences walk, multiply, divide, fix, output
    apl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // datapath: breakpoint memory, segment search, interpolation arithmetic
    apl_datapath #(
        .NUM_POINTS (NUM_POINTS),
        .ADC_BITS   (ADC_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_point_index    (i_point_index),
        .i_point_measured (i_point_measured),
        .i_point_ideal    (i_point_ideal),
        .i_raw_code       (i_raw_code),
        .o_corrected_code (o_corrected_code),
        .o_beyond_table   (o_beyond_table)
    );

endmodule

>>> design/apl_datapath.sv
// ----------------------------------------------------------------------------
// apl_datapath
// breakpoint memory, segment walk, multiply, restoring divider and output
// ----------------------------------------------------------------------------
module apl_datapath #(
    parameter int NUM_POINTS = apl_pkg::DEF_NUM_POINTS,
    parameter int ADC_BITS   = apl_pkg::DEF_ADC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  apl_pkg::t_cmd             i_cmd,
    output apl_pkg::t_status          o_status,
    input  logic [apl_pkg::IDX_W-1:0] i_point_index,
    input  logic [ADC_BITS-1:0]       i_point_measured,
    input  logic [ADC_BITS-1:0]       i_point_ideal,
    input  logic [ADC_BITS-1:0]       i_raw_code,
    output logic [ADC_BITS-1:0]       o_corrected_code,
    output logic                      o_beyond_table
);
    import apl_pkg::*;

    localparam int AW  = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int CW  = $clog2(NUM_POINTS + 1);
    localparam int DCW = (ADC_BITS > 1) ? $clog2(ADC_BITS) : 1;
    localparam int W2  = 2 * ADC_BITS;

    // breakpoint store: {measured, ideal}
    logic [W2-1:0]         mem [NUM_POINTS];
    logic [NUM_POINTS-1:0] r_vld;
    logic [W2-1:0]         r_rd_data;
    logic                  r_rd_vld;

    logic [CW-1:0]         r_cnt;
    logic [ADC_BITS-1:0]   r_raw;
    logic [ADC_BITS-1:0]   r_prev_m;
    logic [ADC_BITS-1:0]   r_prev_i;
    logic                  r_neg;
    logic [ADC_BITS-1:0]   r_mag;
    logic [ADC_BITS-1:0]   r_dist;
    logic [ADC_BITS-1:0]   r_den;
    logic [ADC_BITS-1:0]   r_rem;
    logic [ADC_BITS-1:0]   r_quo;
    logic [DCW-1:0]        r_dcnt;
    logic [ADC_BITS-1:0]   r_res;
    logic                  r_flag;
    logic [ADC_BITS-1:0]   r_out_code;
    logic                  r_out_flag;

    logic                  wr_en;
    logic                  rd_en;
    logic [AW-1:0]         raddr;
    logic [ADC_BITS-1:0]   rd_m;
    logic [ADC_BITS-1:0]   rd_i;
    logic                  used;
    logic                  above;
    logic [ADC_BITS:0]     diff;
    logic [W2-1:0]         prod;
    logic [ADC_BITS:0]     trial;
    logic                  ge;
    logic [ADC_BITS:0]     trial_sub;
    logic signed [ADC_BITS+1:0] sum;

    assign wr_en = i_cmd.load_wr &&
                   ({1'b0, i_point_index} < (IDX_W + 1)'(NUM_POINTS));
    assign rd_en = i_cmd.rd_step && (r_cnt < CW'(NUM_POINTS));
    assign raddr = r_cnt[AW-1:0];

    // slot never written reads as zero
    assign rd_m  = r_rd_vld ? r_rd_data[W2-1:ADC_BITS] : '0;
    assign rd_i  = r_rd_vld ? r_rd_data[ADC_BITS-1:0]  : '0;
    assign used  = (rd_m != '0);
    assign above = (rd_m > r_raw);

    assign diff      = {1'b0, rd_i} - {1'b0, r_prev_i};
    assign prod      = W2'(r_mag) * W2'(r_dist);
    assign trial     = {r_rem, r_quo[ADC_BITS-1]};
    assign ge        = (trial >= {1'b0, r_den});
    assign trial_sub = trial - {1'b0, r_den};

    always_comb begin
        if (r_neg) begin
            sum = signed'({2'b00, r_prev_i}) - signed'({2'b00, r_quo});
        end else begin
            sum = signed'({2'b00, r_prev_i}) + signed'({2'b00, r_quo});
        end
    end

    always_comb begin
        o_status.raw_full = &r_raw;
        o_status.hit      = used && above;
        o_status.last     = (r_cnt == CW'(NUM_POINTS));
        o_status.div_last = (r_dcnt == DCW'(ADC_BITS - 1));
    end

    // memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[i_point_index[AW-1:0]] <= {i_point_measured, i_point_ideal};
        end
        if (rd_en) begin
            r_rd_data <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[i_point_index[AW-1:0]] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_vld[raddr];
            end
        end
    end

    // walk counter and divider step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_cmd.start) begin
                r_cnt <= '0;
            end else if (rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.mul_en) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + DCW'(1);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_raw    <= i_raw_code;
            r_prev_m <= '0;
            r_prev_i <= '0;
        end
        if (i_cmd.walk_en && used) begin
            if (above) begin
                r_neg  <= diff[ADC_BITS];
                r_mag  <= diff[ADC_BITS] ? ADC_BITS'(-diff) : diff[ADC_BITS-1:0];
                r_dist <= r_raw - r_prev_m;
                r_den  <= rd_m - r_prev_m;
            end else begin
                r_prev_m <= rd_m;
                r_prev_i <= rd_i;
            end
        end
        // upper half is below the divisor, so only the low half needs steps
        if (i_cmd.mul_en) begin
            r_rem <= prod[W2-1:ADC_BITS];
            r_quo <= prod[ADC_BITS-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? trial_sub[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
            r_quo <= {r_quo[ADC_BITS-2:0], ge};
        end
        if (i_cmd.fix_en) begin
            r_flag <= 1'b0;
            if (sum < 0) begin
                r_res <= '0;
            end else if (sum > signed'({2'b00, {ADC_BITS{1'b1}}})) begin
                r_res <= '1;
            end else begin
                r_res <= sum[ADC_BITS-1:0];
            end
        end else if (i_cmd.set_full) begin
            r_res  <= '1;
            r_flag <= 1'b0;
        end else if (i_cmd.set_beyond) begin
            r_res  <= '1;
            r_flag <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_code <= r_res;
            r_out_flag <= r_flag;
        end
    end

    assign o_corrected_code = r_out_code;
    assign o_beyond_table   = r_out_flag;

endmodule

>>> design/apl_ctrl.sv
// ----------------------------------------------------------------------------
// apl_ctrl
// sequencer for breakpoint loads and sample correction, owns the handshakes
// ----------------------------------------------------------------------------
module apl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_kind,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output apl_pkg::t_cmd    o_cmd,
    input  apl_pkg::t_status i_status
);
    import apl_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == KIND_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_READ;
                    end
                end
            end
            S_READ: begin
                if (i_status.raw_full) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.rd_step = 1'b1;
                    n_state       = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.rd_step = 1'b1;
                o_cmd.walk_en = 1'b1;
                if (i_status.hit) begin
                    n_state = S_MUL;
                end else if (i_status.last) begin
                    o_cmd.set_beyond = 1'b1;
                    n_state          = S_OUT;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix_en = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_out_vld || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_vld   = o_cmd.out_load || (r_out_vld && i_out_stall);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

>>> design/apl_checker.sv
// ----------------------------------------------------------------------------
// apl_checker
// port-level checks for the adc piecewise linear correction block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apl_checker #(
    parameter int ADC_BITS = apl_pkg::DEF_ADC_BITS
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                i_kind,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [ADC_BITS-1:0] o_corrected_code,
    input logic                o_beyond_table
);
    import apl_pkg::*;

    `APL_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "result dropped while stalled")
    `APL_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable(o_corrected_code) && $stable(o_beyond_table), "stalled result changed")
    `APL_ASSERT(a_beyond_full, i_clk, i_rst_n, o_out_valid && o_beyond_table |-> (o_corrected_code == {ADC_BITS{1'b1}}), "beyond flag without full-scale code")
    `APL_ASSERT(a_sample_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_kind == KIND_SAMPLE) |=> o_in_stall, "sample transfer did not start work")
    `APL_ASSERT(a_load_quick, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_kind == KIND_LOAD) |=> !o_in_stall, "load transfer held the input")

endmodule

bind adc_piecewise_linear_correction apl_checker #(
    .ADC_BITS (ADC_BITS)
) u_apl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_kind           (i_kind),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_corrected_code (o_corrected_code),
    .o_beyond_table   (o_beyond_table)
);
